>>> rtl/rgbpk_pkg.sv
// Package for the RGB pixel bit packer: payload types, state codes, register indexes, helpers.
package rgbpk_pkg;

    // Input beat: one pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       line_end;
    } t_pixel;

    // Output beat: one packed word
    typedef struct packed {
        logic [31:0] data_word;
        logic        last_of_run;
    } t_result;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHUNK,
        S_FLUSH,
        S_LAST
    } t_state;

    // Configuration register indexes
    localparam logic [2:0] CFG_WORD_LENGTH   = 3'd0;
    localparam logic [2:0] CFG_PACK_MODE     = 3'd1;
    localparam logic [2:0] CFG_RED_BITS      = 3'd2;
    localparam logic [2:0] CFG_GREEN_BITS    = 3'd3;
    localparam logic [2:0] CFG_BLUE_BITS     = 3'd4;
    localparam logic [2:0] CFG_CHANNEL_ORDER = 3'd5;
    localparam logic [2:0] CFG_LITTLE_ENDIAN = 3'd6;
    localparam logic [2:0] CFG_MIRROR_BITS   = 3'd7;

    // Channel select codes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_NONE  = 2'd3;

    // Channel order codes
    localparam logic [2:0] ORD_RGB = 3'd0;
    localparam logic [2:0] ORD_RBG = 3'd1;
    localparam logic [2:0] ORD_GRB = 3'd2;
    localparam logic [2:0] ORD_GBR = 3'd3;
    localparam logic [2:0] ORD_BRG = 3'd4;
    localparam logic [2:0] ORD_BGR = 3'd5;

    // Saturate a channel bit count at eight
    function automatic logic [3:0] f_clamp8(input logic [3:0] n);
        return (n > 4'd8) ? 4'd8 : n;
    endfunction

    // Channel emitted in a given slot of a given order; none past slot 2 or for bad orders
    function automatic logic [1:0] f_seq(input logic [2:0] order, input logic [1:0] slot);
        logic [5:0] s;
        unique case (order)
            ORD_RGB: s = {CH_RED,   CH_GREEN, CH_BLUE};
            ORD_RBG: s = {CH_RED,   CH_BLUE,  CH_GREEN};
            ORD_GRB: s = {CH_GREEN, CH_RED,   CH_BLUE};
            ORD_GBR: s = {CH_GREEN, CH_BLUE,  CH_RED};
            ORD_BRG: s = {CH_BLUE,  CH_RED,   CH_GREEN};
            ORD_BGR: s = {CH_BLUE,  CH_GREEN, CH_RED};
            default: s = {CH_NONE,  CH_NONE,  CH_NONE};
        endcase
        unique case (slot)
            2'd0:    return s[5:4];
            2'd1:    return s[3:2];
            2'd2:    return s[1:0];
            default: return CH_NONE;
        endcase
    endfunction

    // Optional byte swap within the word, optional bit mirror per byte, upper bytes cleared
    function automatic logic [31:0] f_finish(input logic [31:0] w, input logic [1:0] code,
                                             input logic le, input logic mir);
        logic [3:0][7:0] b;
        logic [3:0][7:0] t;
        logic [31:0]     r;
        b = w;
        for (int i = 0; i < 4; i++) begin
            t[i] = (i <= int'(code)) ? b[code - 2'(i)] : 8'h00;
        end
        if (le) begin
            b = t;
        end
        if (mir) begin
            for (int i = 0; i < 4; i++) begin
                for (int k = 0; k < 8; k++) begin
                    t[i][7-k] = b[i][k];
                end
            end
            b = t;
        end
        for (int i = 0; i < 4; i++) begin
            if (i > int'(code)) begin
                b[i] = 8'h00;
            end
        end
        r = b;
        return r;
    endfunction

endpackage

>>> rtl/rgb_pixel_bit_packer.sv
// RGB pixel bit packer: pixel intake, chunk sequencer, threshold unit and output register.
//
//  Channel | Signals                              | Beat
//  --------+--------------------------------------+-------------------------------
//  in      | i_in_valid, o_in_stall, i_in_data    | one pixel (t_pixel)
//  out     | o_out_valid, i_out_stall, o_out_data | one word (t_result)
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data    | one register write
//
// A pixel passes through intake, one shift-and-merge step per channel when none of its
// channels splits across words, an end-of-order step, flush and last-word release.
// Each extra word that a channel splits into adds one step; a word waiting on a stalled
// output holds the sequencer. After any register write the threshold unit runs, one add
// of bits-per-pixel a cycle, and the input stalls until it is done.
// Reset is synchronous, active low, loads the register defaults and empties the word.
module rgb_pixel_bit_packer
    import rgbpk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_pixel     i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_result    o_out_data,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [3:0] i_cfg_data
);

    // Configuration registers
    logic [1:0]  r_wlen,  n_wlen;
    logic        r_pack,  n_pack;
    logic [3:0]  r_rbits, n_rbits;
    logic [3:0]  r_gbits, n_gbits;
    logic [3:0]  r_bbits, n_bbits;
    logic [2:0]  r_order, n_order;
    logic        r_le,    n_le;
    logic        r_mir,   n_mir;

    // Sequencer and accumulator
    t_state      r_state, n_state;
    logic [1:0]  r_c,     n_c;
    logic [3:0]  r_i,     n_i;
    logic [31:0] r_acc,   n_acc;
    logic [5:0]  r_cnt,   n_cnt;
    t_pixel      r_pix,   n_pix;

    // Threshold unit
    logic        r_thr_busy, n_thr_busy;
    logic [5:0]  r_thr,      n_thr;

    // Pending word and output register
    logic        r_pend_v, n_pend_v;
    logic [31:0] r_pend,   n_pend;
    logic        r_out_v,  n_out_v;
    t_result     r_out,    n_out;

    logic        w_push;
    logic        w_push_last;
    logic        w_out_free;
    logic [5:0]  w_len;
    logic [4:0]  w_bpp;
    logic [1:0]  w_s;
    logic [3:0]  w_nb;
    logic [7:0]  w_chan;
    logic [3:0]  w_rem;
    logic [5:0]  w_room;
    logic        w_over;
    logic [3:0]  w_k;
    logic [7:0]  w_tmp;
    logic [7:0]  w_chunk;
    logic [5:0]  w_pos;
    logic [31:0] w_place;
    logic [31:0] w_acc_new;
    logic [5:0]  w_cnt_new;
    logic        w_emit;
    logic [4:0]  w_i_next;
    logic [6:0]  w_thr_try;

    // Derived word length and bits per pixel
    assign w_len = 6'(({4'b0, r_wlen} + 6'd1) << 3);
    assign w_bpp = 5'(f_clamp8(r_rbits)) + 5'(f_clamp8(r_gbits)) + 5'(f_clamp8(r_bbits));
    assign w_out_free = !r_out_v || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || r_thr_busy;
    assign o_out_valid = r_out_v;
    assign o_out_data = r_out;

    // Current channel of the sequencer
    always_comb begin
        w_s = f_seq(r_order, r_c);
        unique case (w_s)
            CH_RED: begin
                w_nb   = f_clamp8(r_rbits);
                w_chan = r_pix.red;
            end
            CH_GREEN: begin
                w_nb   = f_clamp8(r_gbits);
                w_chan = r_pix.green;
            end
            CH_BLUE: begin
                w_nb   = f_clamp8(r_bbits);
                w_chan = r_pix.blue;
            end
            default: begin
                w_nb   = 4'd0;
                w_chan = 8'h00;
            end
        endcase
    end

    // Shared shift-and-merge unit: take up to the room left before the threshold
    always_comb begin
        w_rem  = w_nb - r_i;
        w_room = r_thr - r_cnt;
        w_over = r_cnt >= r_thr;
        if (w_over) begin
            w_k = 4'd1;
        end else if ({2'b0, w_rem} <= w_room) begin
            w_k = w_rem;
        end else begin
            w_k = w_room[3:0];
        end
        w_tmp     = w_chan << r_i[2:0];
        w_chunk   = w_tmp >> (4'd8 - w_k);
        w_pos     = w_len - r_cnt - {2'b0, w_k};
        w_place   = (r_cnt < w_len) ? ({24'b0, w_chunk} << w_pos[4:0]) : 32'h0;
        w_acc_new = r_acc | w_place;
        w_cnt_new = r_cnt + {2'b0, w_k};
        w_emit    = w_cnt_new >= r_thr;
        w_i_next  = {1'b0, r_i} + {1'b0, w_k};
        w_thr_try = {1'b0, r_thr} + {2'b0, w_bpp};
    end

    // Next state, sequencer and configuration
    always_comb begin
        n_wlen     = r_wlen;
        n_pack     = r_pack;
        n_rbits    = r_rbits;
        n_gbits    = r_gbits;
        n_bbits    = r_bbits;
        n_order    = r_order;
        n_le       = r_le;
        n_mir      = r_mir;
        n_state    = r_state;
        n_c        = r_c;
        n_i        = r_i;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_pix      = r_pix;
        n_thr_busy = r_thr_busy;
        n_thr      = r_thr;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        w_push      = 1'b0;
        w_push_last = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && !r_thr_busy) begin
                    n_pix   = i_in_data;
                    n_c     = 2'd0;
                    n_i     = 4'd0;
                    n_state = S_CHUNK;
                end
            end
            S_CHUNK: begin
                if (w_s == CH_NONE) begin
                    n_state = S_FLUSH;
                end else if (r_i >= w_nb) begin
                    n_c = r_c + 2'd1;
                    n_i = 4'd0;
                end else if (!(w_emit && r_pend_v && !w_out_free)) begin
                    if (w_i_next >= {1'b0, w_nb}) begin
                        n_c = r_c + 2'd1;
                        n_i = 4'd0;
                    end else begin
                        n_i = w_i_next[3:0];
                    end
                    if (w_emit) begin
                        w_push   = r_pend_v;
                        n_pend   = f_finish(w_acc_new, r_wlen, r_le, r_mir);
                        n_pend_v = 1'b1;
                        n_acc    = 32'h0;
                        n_cnt    = 6'd0;
                    end else begin
                        n_acc = w_acc_new;
                        n_cnt = w_cnt_new;
                    end
                end
            end
            S_FLUSH: begin
                if (r_pix.line_end && (r_cnt != 6'd0)) begin
                    if (!(r_pend_v && !w_out_free)) begin
                        w_push   = r_pend_v;
                        n_pend   = f_finish(r_acc, r_wlen, r_le, r_mir);
                        n_pend_v = 1'b1;
                        n_acc    = 32'h0;
                        n_cnt    = 6'd0;
                        n_state  = S_LAST;
                    end
                end else begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                if (r_pend_v) begin
                    if (w_out_free) begin
                        w_push      = 1'b1;
                        w_push_last = 1'b1;
                        n_pend_v    = 1'b0;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Threshold unit: largest bits-per-pixel multiple in word; whole word if packed
        if (r_thr_busy) begin
            if (r_pack || (w_bpp == 5'd0)) begin
                n_thr      = w_len;
                n_thr_busy = 1'b0;
            end else if (w_thr_try <= {1'b0, w_len}) begin
                n_thr = w_thr_try[5:0];
            end else begin
                n_thr_busy = 1'b0;
            end
        end

        // Register writes; a new word length drops the partial word
        if (i_cfg_we) begin
            n_thr_busy = 1'b1;
            n_thr      = 6'd0;
            unique case (i_cfg_index)
                CFG_WORD_LENGTH: begin
                    n_wlen = i_cfg_data[1:0];
                    if (i_cfg_data[1:0] != r_wlen) begin
                        n_acc = 32'h0;
                        n_cnt = 6'd0;
                    end
                end
                CFG_PACK_MODE:     n_pack  = i_cfg_data[0];
                CFG_RED_BITS:      n_rbits = i_cfg_data;
                CFG_GREEN_BITS:    n_gbits = i_cfg_data;
                CFG_BLUE_BITS:     n_bbits = i_cfg_data;
                CFG_CHANNEL_ORDER: n_order = i_cfg_data[2:0];
                CFG_LITTLE_ENDIAN: n_le    = i_cfg_data[0];
                CFG_MIRROR_BITS:   n_mir   = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Output register next value
    always_comb begin
        n_out_v = r_out_v && i_out_stall;
        n_out   = r_out;
        if (w_push) begin
            n_out_v           = 1'b1;
            n_out.data_word   = r_pend;
            n_out.last_of_run = w_push_last;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen     <= 2'd0;
            r_pack     <= 1'b1;
            r_rbits    <= 4'd3;
            r_gbits    <= 4'd2;
            r_bbits    <= 4'd3;
            r_order    <= ORD_RGB;
            r_le       <= 1'b0;
            r_mir      <= 1'b0;
            r_state    <= S_IDLE;
            r_c        <= 2'd0;
            r_i        <= 4'd0;
            r_acc      <= 32'h0;
            r_cnt      <= 6'd0;
            r_thr_busy <= 1'b0;
            r_thr      <= 6'd8;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_wlen     <= n_wlen;
            r_pack     <= n_pack;
            r_rbits    <= n_rbits;
            r_gbits    <= n_gbits;
            r_bbits    <= n_bbits;
            r_order    <= n_order;
            r_le       <= n_le;
            r_mir      <= n_mir;
            r_state    <= n_state;
            r_c        <= n_c;
            r_i        <= n_i;
            r_acc      <= n_acc;
            r_cnt      <= n_cnt;
            r_thr_busy <= n_thr_busy;
            r_thr      <= n_thr;
            r_pend_v   <= n_pend_v;
            r_out_v    <= n_out_v;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pix  <= n_pix;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    // Bit count never runs past the word
    a_cnt_in_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= w_len)
        else $error("bit count beyond word length");

    // A settled threshold fits the word
    a_thr_in_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_thr_busy |-> (r_thr <= w_len))
        else $error("threshold beyond word length");

    // No word is left pending between pixels
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("pending word while idle");

    // An accepted pixel starts the channel steps
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_CHUNK))
        else $error("accepted pixel did not start");

    // Only the release step marks the last word of a pixel
    a_last_from_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && (r_state != S_LAST)) |=> !o_out_data.last_of_run)
        else $error("last word flagged early");

endmodule
